// File: hdl/hbac_pkg.sv
package hbac_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int OP_W   = 3;
   localparam int ADDR_W = 64;
   localparam int LEN_W  = 32;
   localparam int STS_W  = 3;
   localparam int BLK_W  = 2;
   localparam int WIN_W  = 32;

   localparam logic [WIN_W-1:0] STACK_WINDOW_RESET = 32'h0010_0000;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC_UNDEF = 3'd0,
      OP_ALLOC_ZERO  = 3'd1,
      OP_FREE        = 3'd2,
      OP_REALLOC     = 3'd3,
      OP_ACCESS      = 3'd4
   } op_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK          = 3'd0,
      STS_INV_READ    = 3'd1,
      STS_INV_WRITE   = 3'd2,
      STS_UNINIT_READ = 3'd3,
      STS_DOUBLE_FREE = 3'd4,
      STS_INV_FREE    = 3'd5,
      STS_TABLE_FULL  = 3'd6
   } status_type;

   typedef enum logic [BLK_W-1:0] {
      BLK_DEFINED   = 2'd0,
      BLK_UNDEFINED = 2'd1,
      BLK_FREED     = 2'd3
   } blk_type;

   typedef enum logic [1:0] {
      MODE_FREE,
      MODE_REALLOC,
      MODE_ACCESS
   } mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_HANDLE,
      S_RECORD,
      S_STACK_SUB,
      S_STACK_CMP,
      S_DONE
   } fsm_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [LEN_W-1:0]  len;
      blk_type           st;
   } entry_type;

   typedef struct packed {
      logic              hit;
      logic              borrow;
      logic [ADDR_W-1:0] diff;
   } cmp_res_type;

endpackage

// File: hdl/hbac_req_if.sv
interface hbac_req_if;
   import hbac_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [ADDR_W-1:0] addr;
   logic [ADDR_W-1:0] new_addr;
   logic [LEN_W-1:0]  size;
   logic              wr_access;
   logic [ADDR_W-1:0] stack_ptr;

   modport source (output valid, op, addr, new_addr, size, wr_access, stack_ptr, input ready);
   modport sink (input valid, op, addr, new_addr, size, wr_access, stack_ptr, output ready);
endinterface

// File: hdl/hbac_rsp_if.sv
interface hbac_rsp_if;
   import hbac_pkg::*;

   logic             valid;
   logic             ready;
   logic [STS_W-1:0] status;
   logic             block_found;
   logic [BLK_W-1:0] block_state;

   modport source (output valid, status, block_found, block_state, input ready);
   modport sink (input valid, status, block_found, block_state, output ready);
endinterface

// File: hdl/hbac_csr_if.sv
interface hbac_csr_if;
   import hbac_pkg::*;

   logic             valid;
   logic             ready;
   logic [WIN_W-1:0] stack_window;

   modport source (output valid, stack_window, input ready);
   modport sink (input valid, stack_window, output ready);
endinterface

// File: hdl/hbac_ram.sv
module hbac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/hbac_cmp.sv
// Shared 64-bit subtract/compare: a - b, and whether a lies in [b, b+len).
module hbac_cmp (
   input  logic [hbac_pkg::ADDR_W-1:0] a,
   input  logic [hbac_pkg::ADDR_W-1:0] b,
   input  logic [hbac_pkg::LEN_W-1:0]  len,
   output hbac_pkg::cmp_res_type       res
);
   import hbac_pkg::*;

   logic [ADDR_W:0] diff_w;

   assign diff_w = {1'b0, a} - {1'b0, b};

   always_comb begin
      res.borrow = diff_w[ADDR_W];
      res.diff   = diff_w[ADDR_W-1:0];
      res.hit    = !diff_w[ADDR_W]
                   && (diff_w[ADDR_W-1:LEN_W] == '0)
                   && (diff_w[LEN_W-1:0] < len);
   end

endmodule

// File: hdl/heap_block_access_checker_core.sv
// A null free, a null access or an unused op goes straight from decode to the result; an
// allocation records its block first; a table lookup scans the entries in use, newest first,
// and stops early at the newest matching entry.
// Throughput: one beat at a time, the next taken the cycle after the result register loads;
// the table scan reads one entry per cycle from a single RAM read port and sets the rate.
// Reset: synchronous, active high; empties the table, stack_window to 0x100000, no result.
module heap_block_access_checker_core (
   input  logic       clock,
   input  logic       reset,
   hbac_req_if.sink   req_ch,
   hbac_rsp_if.source rsp_ch,
   hbac_csr_if.sink   csr_ch
);
   import hbac_pkg::*;

   fsm_type                state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [ADDR_W-1:0]      new_addr_ff, new_addr_in;
   logic [LEN_W-1:0]       size_ff, size_in;
   logic                   wr_ff, wr_in;
   logic [ADDR_W-1:0]      sp_ff, sp_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [CNT_W-1:0]       scan_cnt_ff, scan_cnt_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   entry_type              hit_ent_ff, hit_ent_in;
   status_type             status_ff, status_in;
   logic                   found_ff, found_in;
   logic [BLK_W-1:0]       bstate_ff, bstate_in;
   logic [ADDR_W-1:0]      dist_ff, dist_in;
   logic [WIN_W-1:0]       window_ff, window_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [BLK_W-1:0]       rsp_bstate_ff, rsp_bstate_in;

   logic                   accept;
   logic                   load_rsp;
   logic [CNT_W-1:0]       scan_dec;
   logic                   ram_we;
   logic [IDX_W-1:0]       ram_waddr;
   entry_type              ram_wdata;
   logic                   ram_re;
   logic [IDX_W-1:0]       ram_raddr;
   entry_type              ram_rdata;
   logic [ADDR_W-1:0]      cmp_b;
   logic [LEN_W-1:0]       cmp_len;
   cmp_res_type            cmp_res;
   logic [ADDR_W-1:0]      rec_base;
   blk_type                rec_st;
   blk_type                new_st;
   status_type             bad_access;

   hbac_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // scan compares against table entries, the stack test against the stack pointer
   assign cmp_b   = (state_ff == S_SCAN) ? ram_rdata.base : sp_ff;
   assign cmp_len = ram_rdata.len;

   hbac_cmp u_cmp (
      .a   (addr_ff),
      .b   (cmp_b),
      .len (cmp_len),
      .res (cmp_res)
   );

   assign accept     = req_ch.valid && req_ch.ready;
   assign scan_dec   = scan_cnt_ff - CNT_W'(1);
   assign bad_access = wr_ff ? STS_INV_WRITE : STS_INV_READ;

   always_comb begin
      unique case (op_ff)
         OP_REALLOC: begin
            rec_base = new_addr_ff;
            rec_st   = BLK_UNDEFINED;
         end
         OP_ALLOC_ZERO: begin
            rec_base = addr_ff;
            rec_st   = BLK_DEFINED;
         end
         default: begin
            rec_base = addr_ff;
            rec_st   = BLK_UNDEFINED;
         end
      endcase
   end

   // status a hit entry takes after this beat
   always_comb begin
      new_st = hit_ent_ff.st;
      if (mode_ff != MODE_ACCESS) begin
         new_st = BLK_FREED;
      end else if (hit_ent_ff.st == BLK_UNDEFINED && wr_ff) begin
         new_st = BLK_DEFINED;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (op_ff)
               OP_ALLOC_UNDEF, OP_ALLOC_ZERO: state_in = S_RECORD;
               OP_FREE:    state_in = (addr_ff == '0) ? S_DONE : S_SCAN;
               OP_REALLOC: begin
                  priority if (addr_ff == '0) begin
                     state_in = S_RECORD;
                  end else if (size_ff == '0 || new_addr_ff != '0) begin
                     state_in = S_SCAN;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               OP_ACCESS:  state_in = (addr_ff == '0) ? S_DONE : S_SCAN;
               default:    state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            if ((pend_ff && cmp_res.hit) || (!pend_ff && scan_cnt_ff == '0)) begin
               state_in = S_HANDLE;
            end
         end
         S_HANDLE: begin
            unique case (mode_ff)
               MODE_REALLOC: state_in = S_RECORD;
               MODE_ACCESS:  state_in = hit_ff ? S_DONE : S_STACK_SUB;
               default:      state_in = S_DONE;
            endcase
         end
         S_RECORD:    state_in = S_DONE;
         S_STACK_SUB: state_in = S_STACK_CMP;
         S_STACK_CMP: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = hit_idx_ff;
      ram_wdata = '{base: hit_ent_ff.base, len: hit_ent_ff.len, st: new_st};
      ram_re    = 1'b0;
      ram_raddr = scan_dec[IDX_W-1:0];
      load_rsp  = 1'b0;
      unique case (state_ff)
         S_SCAN: begin
            ram_re = (scan_cnt_ff != '0);
         end
         S_HANDLE: begin
            ram_we = hit_ff && (new_st != hit_ent_ff.st);
         end
         S_RECORD: begin
            ram_waddr = fill_ff[IDX_W-1:0];
            ram_wdata = '{base: rec_base, len: size_ff, st: rec_st};
            ram_we    = (rec_base != '0) && (fill_ff < CNT_W'(TABLE_ENTRIES));
         end
         S_DONE: begin
            load_rsp = !rsp_valid_ff || rsp_ch.ready;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      op_in         = op_ff;
      addr_in       = addr_ff;
      new_addr_in   = new_addr_ff;
      size_in       = size_ff;
      wr_in         = wr_ff;
      sp_in         = sp_ff;
      mode_in       = mode_ff;
      fill_in       = fill_ff;
      scan_cnt_in   = scan_cnt_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_ent_in    = hit_ent_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      bstate_in     = bstate_ff;
      dist_in       = dist_ff;
      window_in     = window_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_bstate_in = rsp_bstate_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (csr_ch.valid) begin
         window_in = csr_ch.stack_window;
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_ch.op;
               addr_in     = req_ch.addr;
               new_addr_in = req_ch.new_addr;
               size_in     = req_ch.size;
               wr_in       = req_ch.wr_access;
               sp_in       = req_ch.stack_ptr;
               status_in   = STS_OK;
               found_in    = 1'b0;
               bstate_in   = '0;
            end
         end
         S_DECODE: begin
            scan_cnt_in = fill_ff;
            pend_in     = 1'b0;
            hit_in      = 1'b0;
            mode_in     = MODE_FREE;
            if (op_ff == OP_ACCESS) begin
               mode_in = MODE_ACCESS;
               if (addr_ff == '0) begin
                  status_in = bad_access;
               end
            end else if (op_ff == OP_REALLOC && size_ff != '0) begin
               mode_in = MODE_REALLOC;
            end
         end
         S_SCAN: begin
            // entries are read newest first; data for pend_idx arrives in the next cycle
            pend_in     = (scan_cnt_ff != '0);
            pend_idx_in = scan_dec[IDX_W-1:0];
            if (scan_cnt_ff != '0) begin
               scan_cnt_in = scan_dec;
            end
            if (pend_ff && cmp_res.hit) begin
               hit_in     = 1'b1;
               hit_idx_in = pend_idx_ff;
               hit_ent_in = ram_rdata;
            end
         end
         S_HANDLE: begin
            if (hit_ff) begin
               found_in  = 1'b1;
               bstate_in = hit_ent_ff.st;
            end
            unique case (mode_ff)
               MODE_FREE: begin
                  if (!hit_ff) begin
                     status_in = STS_INV_FREE;
                  end else if (hit_ent_ff.st == BLK_FREED) begin
                     status_in = STS_DOUBLE_FREE;
                  end
               end
               MODE_ACCESS: begin
                  if (hit_ff) begin
                     if (hit_ent_ff.st == BLK_FREED) begin
                        status_in = bad_access;
                     end else if (hit_ent_ff.st == BLK_UNDEFINED && !wr_ff) begin
                        status_in = STS_UNINIT_READ;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_RECORD: begin
            if (rec_base != '0) begin
               if (fill_ff < CNT_W'(TABLE_ENTRIES)) begin
                  fill_in = fill_ff + CNT_W'(1);
               end else begin
                  status_in = STS_TABLE_FULL;
               end
            end
         end
         S_STACK_SUB: begin
            dist_in = cmp_res.borrow ? (sp_ff - addr_ff) : cmp_res.diff;
         end
         S_STACK_CMP: begin
            if (dist_ff >= {{(ADDR_W-WIN_W){1'b0}}, window_ff}) begin
               status_in = bad_access;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               rsp_bstate_in = bstate_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         window_ff    <= STACK_WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      new_addr_ff   <= new_addr_in;
      size_ff       <= size_in;
      wr_ff         <= wr_in;
      sp_ff         <= sp_in;
      mode_ff       <= mode_in;
      scan_cnt_ff   <= scan_cnt_in;
      pend_ff       <= pend_in;
      pend_idx_ff   <= pend_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_ent_ff    <= hit_ent_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      bstate_ff     <= bstate_in;
      dist_ff       <= dist_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_bstate_ff <= rsp_bstate_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.block_found = rsp_found_ff;
   assign rsp_ch.block_state = rsp_bstate_ff;

endmodule

// File: hdl/hbac_chk.sv
module hbac_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [hbac_pkg::STS_W-1:0] rsp_status,
   input logic                      rsp_found,
   input logic [hbac_pkg::BLK_W-1:0] rsp_bstate
);
   import hbac_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found) && $stable(rsp_bstate))
      else $error("result beat changed while stalled");

   // one beat in flight: the block drops ready right after taking a beat
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an accepted beat");

   a_uninit_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_UNINIT_READ |-> rsp_found && rsp_bstate == BLK_UNDEFINED)
      else $error("uninitialized read without an undefined block");

   a_double_free_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STS_DOUBLE_FREE |-> rsp_found && rsp_bstate == BLK_FREED)
      else $error("double free without a freed block");

   // double free and uninitialized read both need a block
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_bstate == '0 && rsp_status != STS_DOUBLE_FREE
         && rsp_status != STS_UNINIT_READ)
      else $error("block state or status inconsistent with no block found");

endmodule

bind heap_block_access_checker_core hbac_chk u_hbac_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_found  (rsp_ch.block_found),
   .rsp_bstate (rsp_ch.block_state)
);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import hbac_pkg::*;

   localparam int RANDOM_EVENTS = 1650;
   localparam int PHASES        = 4;
   localparam int DRAIN_CYCLES  = 80;
   localparam int STALL_LIMIT   = 4000;
   localparam int PRINT_LIMIT   = 40;
   localparam int DIRECTED_ROWS = 27;

   localparam logic [OP_W-1:0]   OP_UNUSED_LO = 3'd5;
   localparam logic [OP_W-1:0]   OP_UNUSED_HI = 3'd7;
   localparam blk_type           NO_BLOCK     = BLK_DEFINED;   // state field when nothing hit
   localparam logic [ADDR_W-1:0] HEAP_REGION  = 64'h0000_5555_0000_0000;
   localparam logic [ADDR_W-1:0] STACK_REGION = 64'h0000_7ffd_0000_0000;
   localparam logic [ADDR_W-1:0] ALL_ONES     = {ADDR_W{1'b1}};

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] new_addr;
      logic [LEN_W-1:0]  size;
      logic              wr_access;
      logic [ADDR_W-1:0] stack_ptr;
   } heap_event_type;

   typedef struct packed {
      status_type status;
      logic       found;
      blk_type    state;
   } verdict_type;

   typedef struct packed {
      heap_event_type ev;
      logic           typed;
      verdict_type    want;
   } directed_row_type;

   localparam verdict_type CLEAN_VERDICT = '{STS_OK, 1'b0, NO_BLOCK};

   logic clock;
   logic reset;

   hbac_req_if req_ch();
   hbac_rsp_if rsp_ch();
   hbac_csr_if csr_ch();

   heap_block_access_checker_core uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // shadow of the block table
   entry_type        heap_table [TABLE_ENTRIES];
   int               heap_fill = 0;
   logic [WIN_W-1:0] window_model = STACK_WINDOW_RESET;

   verdict_type pending_verdicts [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          send_gap_pct = 0;
   int          recv_stall_pct = 0;

   int               gap_by_phase   [PHASES] = '{0, 83, 0, 11};
   int               stall_by_phase [PHASES] = '{0, 0, 83, 11};
   logic [WIN_W-1:0] window_by_phase [PHASES] = '{32'hFFFF_FFFF, 32'h0, 32'h0000_1000, 32'h0};

   directed_row_type directed_steps [DIRECTED_ROWS] = '{
      '{'{OP_ACCESS, 64'h0, 64'h0, 32'h0, 1'b0, 64'h0}, 1'b1, '{STS_INV_READ, 1'b0, NO_BLOCK}},
      '{'{OP_ACCESS, 64'h0, 64'h0, 32'hFFFF_FFFF, 1'b1, 64'h0}, 1'b1,
        '{STS_INV_WRITE, 1'b0, NO_BLOCK}},
      '{'{OP_FREE, 64'h0, 64'h0, 32'h0, 1'b0, 64'h0}, 1'b1, '{STS_OK, 1'b0, NO_BLOCK}},
      '{'{OP_ALLOC_UNDEF, 64'h0, 64'h0, 32'h10, 1'b0, 64'h0}, 1'b1, '{STS_OK, 1'b0, NO_BLOCK}},
      '{'{OP_FREE, 64'h1000, 64'h0, 32'h0, 1'b0, 64'h0}, 1'b1, '{STS_INV_FREE, 1'b0, NO_BLOCK}},
      '{'{OP_ALLOC_UNDEF, 64'h1000, 64'h0, 32'h40, 1'b0, 64'h0}, 1'b1, '{STS_OK, 1'b0, NO_BLOCK}},
      '{'{OP_ACCESS, 64'h1010, 64'h0, 32'h4, 1'b0, 64'h0}, 1'b1,
        '{STS_UNINIT_READ, 1'b1, BLK_UNDEFINED}},
      // a write defines the block
      '{'{OP_ACCESS, 64'h1010, 64'h0, 32'h4, 1'b1, 64'h0}, 1'b1, '{STS_OK, 1'b1, BLK_UNDEFINED}},
      '{'{OP_ACCESS, 64'h103F, 64'h0, 32'h1, 1'b0, 64'h0}, 1'b1, '{STS_OK, 1'b1, BLK_DEFINED}},
      // one past the block, exactly one window away from the stack pointer
      '{'{OP_ACCESS, 64'h1040, 64'h0, 32'h1, 1'b0, 64'h10_1040}, 1'b1,
        '{STS_INV_READ, 1'b0, NO_BLOCK}},
      '{'{OP_ALLOC_ZERO, 64'h2000, 64'h0, 32'h0, 1'b0, 64'h0}, 1'b1, '{STS_OK, 1'b0, NO_BLOCK}},
      '{'{OP_ACCESS, 64'h2000, 64'h0, 32'h1, 1'b1, ALL_ONES}, 1'b1,
        '{STS_INV_WRITE, 1'b0, NO_BLOCK}},
      // distance must not wrap around zero
      '{'{OP_ACCESS, 64'h10, 64'h0, 32'h1, 1'b0, 64'hFFFF_FFFF_FFFF_FFF0}, 1'b1,
        '{STS_INV_READ, 1'b0, NO_BLOCK}},
      '{'{OP_ALLOC_ZERO, 64'hFFFF_FFFF_FFFF_F000, 64'h0, 32'hFFFF_FFFF, 1'b0, 64'h0}, 1'b1,
        '{STS_OK, 1'b0, NO_BLOCK}},
      '{'{OP_ACCESS, ALL_ONES, 64'h0, 32'h8, 1'b0, 64'h0}, 1'b1, '{STS_OK, 1'b1, BLK_DEFINED}},
      '{'{OP_FREE, 64'h1020, 64'h0, 32'h0, 1'b0, 64'h0}, 1'b1, '{STS_OK, 1'b1, BLK_DEFINED}},
      '{'{OP_FREE, 64'h1000, 64'h0, 32'h0, 1'b0, 64'h0}, 1'b1,
        '{STS_DOUBLE_FREE, 1'b1, BLK_FREED}},
      '{'{OP_ACCESS, 64'h1008, 64'h0, 32'h4, 1'b1, 64'h1008}, 1'b1,
        '{STS_INV_WRITE, 1'b1, BLK_FREED}},
      '{'{OP_ALLOC_UNDEF, 64'h1000, 64'h0, 32'h10, 1'b0, 64'h0}, 1'b1, '{STS_OK, 1'b0, NO_BLOCK}},
      // overlaps the freed block, newest wins
      '{'{OP_ACCESS, 64'h1004, 64'h0, 32'h4, 1'b0, 64'h0}, 1'b0, CLEAN_VERDICT},
      '{'{OP_REALLOC, 64'h0, 64'h3000, 32'h20, 1'b0, 64'h0}, 1'b1, '{STS_OK, 1'b0, NO_BLOCK}},
      '{'{OP_REALLOC, 64'h3000, 64'h0, 32'h20, 1'b0, 64'h0}, 1'b1, '{STS_OK, 1'b0, NO_BLOCK}},
      '{'{OP_REALLOC, 64'h3010, 64'h4000, 32'h80, 1'b0, 64'h0}, 1'b1,
        '{STS_OK, 1'b1, BLK_UNDEFINED}},
      '{'{OP_REALLOC, 64'h3000, 64'h5000, 32'h8, 1'b0, 64'h0}, 1'b1, '{STS_OK, 1'b1, BLK_FREED}},
      '{'{OP_REALLOC, 64'h4010, 64'h0, 32'h0, 1'b0, 64'h0}, 1'b1, '{STS_OK, 1'b1, BLK_UNDEFINED}},
      '{'{OP_REALLOC, 64'h4010, 64'h6000, 32'h0, 1'b0, 64'h0}, 1'b1,
        '{STS_DOUBLE_FREE, 1'b1, BLK_FREED}},
      '{'{OP_UNUSED_HI, ALL_ONES, ALL_ONES, 32'hFFFF_FFFF, 1'b1, ALL_ONES}, 1'b0, CLEAN_VERDICT}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
   endtask

   // ---------------- predictor ----------------

   function automatic int find_block(input logic [ADDR_W-1:0] a);
      for (int i = heap_fill - 1; i >= 0; i--)
         if (a >= heap_table[i].base && (a - heap_table[i].base) < {32'd0, heap_table[i].len})
            return i;
      return -1;
   endfunction

   function automatic status_type record_block(input logic [ADDR_W-1:0] base,
                                               input logic [LEN_W-1:0] len, input blk_type st);
      if (base == '0)
         return STS_OK;
      if (heap_fill >= TABLE_ENTRIES)
         return STS_TABLE_FULL;
      heap_table[heap_fill] = '{base, len, st};
      heap_fill++;
      return STS_OK;
   endfunction

   function automatic void free_block(input logic [ADDR_W-1:0] a, inout verdict_type v);
      int k;
      if (a == '0)
         return;
      k = find_block(a);
      if (k < 0) begin
         v.status = STS_INV_FREE;
         return;
      end
      v.found = 1'b1;
      v.state = heap_table[k].st;
      if (heap_table[k].st == BLK_FREED)
         v.status = STS_DOUBLE_FREE;
      else
         heap_table[k].st = BLK_FREED;
   endfunction

   function automatic verdict_type predict_heap_event(input heap_event_type ev);
      verdict_type       v;
      int                k;
      logic [ADDR_W-1:0] span;
      v = CLEAN_VERDICT;
      case (ev.op)
         OP_ALLOC_UNDEF: v.status = record_block(ev.addr, ev.size, BLK_UNDEFINED);
         OP_ALLOC_ZERO:  v.status = record_block(ev.addr, ev.size, BLK_DEFINED);
         OP_FREE:        free_block(ev.addr, v);
         OP_REALLOC: begin
            if (ev.addr == '0)
               v.status = record_block(ev.new_addr, ev.size, BLK_UNDEFINED);
            else if (ev.size == '0)
               free_block(ev.addr, v);
            else if (ev.new_addr != '0) begin
               // old block is retired whatever its state, silently
               k = find_block(ev.addr);
               if (k >= 0) begin
                  v.found = 1'b1;
                  v.state = heap_table[k].st;
                  heap_table[k].st = BLK_FREED;
               end
               v.status = record_block(ev.new_addr, ev.size, BLK_UNDEFINED);
            end
         end
         OP_ACCESS: begin
            if (ev.addr == '0) begin
               v.status = ev.wr_access ? STS_INV_WRITE : STS_INV_READ;
            end else begin
               k = find_block(ev.addr);
               if (k < 0) begin
                  span = (ev.addr >= ev.stack_ptr) ? ev.addr - ev.stack_ptr
                                                   : ev.stack_ptr - ev.addr;
                  if (span >= {32'd0, window_model})
                     v.status = ev.wr_access ? STS_INV_WRITE : STS_INV_READ;
               end else begin
                  v.found = 1'b1;
                  v.state = heap_table[k].st;
                  if (heap_table[k].st == BLK_FREED) begin
                     v.status = ev.wr_access ? STS_INV_WRITE : STS_INV_READ;
                  end else if (heap_table[k].st == BLK_UNDEFINED) begin
                     if (ev.wr_access)
                        heap_table[k].st = BLK_DEFINED;
                     else
                        v.status = STS_UNINIT_READ;
                  end
               end
            end
         end
         default: ;
      endcase
      return v;
   endfunction

   // ---------------- random events ----------------

   function automatic logic [ADDR_W-1:0] rand_wide();
      return {$urandom, $urandom};
   endfunction

   // somewhere in or right around a block already in the table, or in the heap region while it is empty
   function automatic logic [ADDR_W-1:0] pick_block_addr();
      entry_type e;
      if (heap_fill == 0)
         return HEAP_REGION + $urandom_range(4095);
      e = heap_table[$urandom_range(heap_fill - 1)];
      case ($urandom_range(9))
         0: return e.base - 1;
         1: return e.base + e.len;
         2: return e.base;
         default: return e.base + ((e.len == '0) ? 32'd0 : $urandom_range(e.len - 1));
      endcase
   endfunction

   function automatic void pick_new_block(output logic [ADDR_W-1:0] base,
                                          output logic [LEN_W-1:0] len);
      base = HEAP_REGION + 16 * $urandom_range(255);
      len  = $urandom_range(96, 1);
      case ($urandom_range(19))
         0: base = '0;
         1: len = '0;
         2: len = '1;
         3: base = rand_wide();
         4: base = ALL_ONES - $urandom_range(4095);
         default: ;
      endcase
   endfunction

   // stack pointer placed around the window edges half of the time
   function automatic logic [ADDR_W-1:0] pick_stack_ptr(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] w;
      w = {32'd0, window_model};
      case ($urandom_range(7))
         0: return a + w;
         1: return a - w;
         2: return a + w - 1;
         3: return a - w + 1;
         4: return rand_wide();
         5: return a;
         default: return a - {32'd0, $urandom} + {32'd0, $urandom};
      endcase
   endfunction

   function automatic heap_event_type make_event();
      heap_event_type ev;
      int             pick;
      ev.op        = OP_ACCESS;
      ev.addr      = pick_block_addr();
      ev.new_addr  = '0;
      ev.size      = $urandom;
      ev.wr_access = 1'($urandom_range(1));
      ev.stack_ptr = rand_wide();
      pick = $urandom_range(99);
      if (pick < 2) begin
         ev.op = OP_ALLOC_UNDEF;
         pick_new_block(ev.addr, ev.size);
      end else if (pick < 3) begin
         ev.op = OP_ALLOC_ZERO;
         pick_new_block(ev.addr, ev.size);
      end else if (pick < 6) begin
         ev.op = OP_REALLOC;
         pick_new_block(ev.new_addr, ev.size);
         case ($urandom_range(9))
            0: ev.addr = '0;
            1: ev.size = '0;
            2: ev.new_addr = '0;
            3: ev.addr = rand_wide();
            default: ;
         endcase
      end else if (pick < 20) begin
         ev.op = OP_FREE;
         case ($urandom_range(9))
            0: ev.addr = '0;
            1: ev.addr = rand_wide();
            default: ;
         endcase
      end else if (pick < 97) begin
         case ($urandom_range(9))
            0: ev.addr = '0;
            1: ev.addr = rand_wide();
            2, 3: ev.addr = STACK_REGION + {32'd0, $urandom};
            default: ;
         endcase
         ev.stack_ptr = pick_stack_ptr(ev.addr);
      end else begin
         ev.op       = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
         ev.addr     = rand_wide();
         ev.new_addr = rand_wide();
      end
      return ev;
   endfunction

   // ---------------- channel drivers ----------------

   task automatic send_event(input heap_event_type ev, input logic typed,
                             input verdict_type want);
      verdict_type predicted;
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.op        <= ev.op;
      req_ch.addr      <= ev.addr;
      req_ch.new_addr  <= ev.new_addr;
      req_ch.size      <= ev.size;
      req_ch.wr_access <= ev.wr_access;
      req_ch.stack_ptr <= ev.stack_ptr;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = predict_heap_event(ev);
      pending_verdicts.push_back(typed ? want : predicted);
   endtask

   task automatic write_stack_window(input logic [WIN_W-1:0] w);
      csr_ch.valid        <= 1'b1;
      csr_ch.stack_window <= w;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      window_model = w;
   endtask

   task automatic drain();
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------- result monitor ----------------

   always @(posedge clock) begin : rsp_monitor
      verdict_type want;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            report_mismatch("result beat with nothing pending", 64'(rsp_ch.status), 64'd0);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_ch.status !== want.status)
               report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
            if (rsp_ch.block_found !== want.found)
               report_mismatch("block_found", 64'(rsp_ch.block_found), 64'(want.found));
            if (rsp_ch.block_state !== want.state)
               report_mismatch("block_state", 64'(rsp_ch.block_state), 64'(want.state));
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      heap_event_type ev;
      int             issued;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.op           = '0;
      req_ch.addr         = '0;
      req_ch.new_addr     = '0;
      req_ch.size         = '0;
      req_ch.wr_access    = 1'b0;
      req_ch.stack_ptr    = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.stack_window = '0;
      window_by_phase[PHASES-1] = $urandom;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_event(directed_steps[i].ev, directed_steps[i].typed, directed_steps[i].want);
      req_ch.valid <= 1'b0;

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         write_stack_window(window_by_phase[ph]);
         send_gap_pct   = gap_by_phase[ph];
         recv_stall_pct = stall_by_phase[ph];
         issued = 0;
         while (issued < RANDOM_EVENTS / PHASES) begin
            ev = make_event();
            send_event(ev, 1'b0, CLEAN_VERDICT);
            if (ev.op <= OP_ACCESS)
               issued++;
         end
         req_ch.valid <= 1'b0;
      end

      drain();
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
